// ----- rtl/pwic_pkg.sv -----
// ----------------------------------------------------------------------------
// pwic_pkg - shared types and microcode for the PID controller
// Holds the control word format, the microcode table, the configuration
// register map and the constants shared by the sequencer and the datapath.
// ----------------------------------------------------------------------------
package pwic_pkg;

    // Serial divider: 50-bit magnitude numerator, two quotient bits per cycle
    localparam int unsigned DIV_NUM_W   = 50;
    localparam int unsigned DIV_STEPS   = DIV_NUM_W / 2;
    localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int unsigned QUO_W       = DIV_NUM_W + 1;

    // Microcode sequencer
    localparam int unsigned PC_W        = 4;
    localparam int unsigned UCODE_LEN   = 9;
    localparam logic [PC_W-1:0] PC_ZERO_OUT = 4'd8;

    // Configuration register map
    typedef enum logic [2:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_INTEG_GAIN  = 3'd1,
        CFG_DERIV_GAIN  = 3'd2,
        CFG_INTEG_LIMIT = 3'd3,
        CFG_OUT_LIMIT   = 3'd4
    } t_cfg_idx;

    localparam logic signed [23:0] CFG_RST_PROP_GAIN   = 24'sd65536;
    localparam logic signed [23:0] CFG_RST_INTEG_GAIN  = 24'sd6554;
    localparam logic signed [23:0] CFG_RST_DERIV_GAIN  = 24'sd3277;
    localparam logic [14:0]        CFG_RST_INTEG_LIMIT = 15'd512;
    localparam logic [14:0]        CFG_RST_OUT_LIMIT   = 15'd1280;

    typedef struct packed {
        logic signed [23:0] prop_gain;
        logic signed [23:0] integ_gain;
        logic signed [23:0] deriv_gain;
        logic [14:0]        integ_limit;
        logic [14:0]        out_limit;
    } t_cfg;

    // Multiplier operand pair select
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_ERR_DT,
        MUL_KD_DERR,
        MUL_KP_ERR,
        MUL_KI_ACC
    } t_mul_sel;

    // Datapath register operation
    typedef enum logic [2:0] {
        ALU_NOP,
        ALU_PREP,
        ALU_INTEG,
        ALU_LOAD_P,
        ALU_ADD_I,
        ALU_ADD_D,
        ALU_FINISH,
        ALU_ZERO
    } t_alu_op;

    // Step condition: a jump, or a hold that stalls the step in place
    typedef enum logic [1:0] {
        COND_NONE,
        COND_DT_NOTPOS,
        COND_DIV_BUSY,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_mul_sel        mul;
        t_alu_op         alu;
        logic            div_start;
        t_cond           cond;
        logic            last;
        logic [PC_W-1:0] target;
    } t_uword;

    // Sequencer to datapath
    typedef struct packed {
        logic     exec;
        t_mul_sel mul;
        t_alu_op  alu;
        logic     div_start;
    } t_ctl;

    // Datapath to sequencer
    typedef struct packed {
        logic dt_notpos;
        logic div_busy;
        logic out_busy;
    } t_sts;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    // Microcode ROM
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{mul: MUL_NONE, alu: ALU_NOP, div_start: 1'b0, cond: COND_NONE,
              last: 1'b0, target: '0};
        case (pc)
            4'd0: begin
                w.alu = ALU_PREP;
            end
            4'd1: begin
                w.mul    = MUL_ERR_DT;
                w.cond   = COND_DT_NOTPOS;
                w.target = PC_ZERO_OUT;
            end
            4'd2: begin
                w.mul = MUL_KD_DERR;
                w.alu = ALU_INTEG;
            end
            4'd3: begin
                w.mul       = MUL_KP_ERR;
                w.div_start = 1'b1;
            end
            4'd4: begin
                w.mul = MUL_KI_ACC;
                w.alu = ALU_LOAD_P;
            end
            4'd5: begin
                w.alu = ALU_ADD_I;
            end
            4'd6: begin
                w.alu  = ALU_ADD_D;
                w.cond = COND_DIV_BUSY;
            end
            4'd7: begin
                w.alu  = ALU_FINISH;
                w.cond = COND_OUT_BUSY;
                w.last = 1'b1;
            end
            4'd8: begin
                w.alu  = ALU_ZERO;
                w.cond = COND_OUT_BUSY;
                w.last = 1'b1;
            end
            default: begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/pwic_div.sv -----
// ----------------------------------------------------------------------------
// pwic_div - serial signed-by-positive divider
// Restoring division of a magnitude by a positive divisor, two quotient bits
// per cycle; the sign is applied at the output (truncation toward zero).
// ----------------------------------------------------------------------------
module pwic_div (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [pwic_pkg::DIV_NUM_W-1:0]         i_num,
    input  logic                                   i_neg,
    input  logic [31:0]                            i_den,
    output logic                                   o_busy,
    output logic signed [pwic_pkg::QUO_W-1:0]      o_quo
);

    logic [30:0]                       r_rem;
    logic [pwic_pkg::DIV_NUM_W-1:0]    r_quo;
    logic [31:0]                       r_den;
    logic                              r_neg;
    logic [pwic_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic                              r_busy;

    logic [31:0] w_t1;
    logic [31:0] w_t2;
    logic        w_ge1;
    logic        w_ge2;
    logic [30:0] w_r1;
    logic [30:0] w_r2;

    // Two restoring steps per cycle
    always_comb begin
        w_t1  = {r_rem, r_quo[pwic_pkg::DIV_NUM_W-1]};
        w_ge1 = (w_t1 >= r_den);
        w_r1  = w_ge1 ? 31'(w_t1 - r_den) : w_t1[30:0];
        w_t2  = {w_r1, r_quo[pwic_pkg::DIV_NUM_W-2]};
        w_ge2 = (w_t2 >= r_den);
        w_r2  = w_ge2 ? 31'(w_t2 - r_den) : w_t2[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= pwic_pkg::DIV_CNT_W'(pwic_pkg::DIV_STEPS - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
            r_neg <= i_neg;
        end else if (r_busy) begin
            r_rem <= w_r2;
            r_quo <= {r_quo[pwic_pkg::DIV_NUM_W-3:0], w_ge1, w_ge2};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

endmodule

// ----- rtl/pwic_seq.sv -----
// ----------------------------------------------------------------------------
// pwic_seq - microcode sequencer
// Steps through the control program, evaluates holds and jumps, and hands
// one control word per cycle to the datapath, except while a hold stalls it.
// ----------------------------------------------------------------------------
module pwic_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_fire,
    input  pwic_pkg::t_sts  i_sts,
    output pwic_pkg::t_ctl  o_ctl,
    output logic            o_idle
);

    pwic_pkg::t_seq_state          r_state;
    pwic_pkg::t_seq_state          n_state;
    logic [pwic_pkg::PC_W-1:0]     r_pc;
    logic [pwic_pkg::PC_W-1:0]     n_pc;

    pwic_pkg::t_uword w_uw;
    logic             w_hold;
    logic             w_jump;

    assign w_uw   = pwic_pkg::ucode(r_pc);
    assign w_hold = ((w_uw.cond == pwic_pkg::COND_DIV_BUSY) && i_sts.div_busy) ||
                    ((w_uw.cond == pwic_pkg::COND_OUT_BUSY) && i_sts.out_busy);
    assign w_jump = (w_uw.cond == pwic_pkg::COND_DT_NOTPOS) && i_sts.dt_notpos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pwic_pkg::SEQ_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_pc            = r_pc;
        o_ctl.exec      = 1'b0;
        o_ctl.mul       = w_uw.mul;
        o_ctl.alu       = w_uw.alu;
        o_ctl.div_start = w_uw.div_start;
        o_idle          = 1'b0;
        case (r_state)
            pwic_pkg::SEQ_IDLE: begin
                o_idle = 1'b1;
                if (i_in_fire) begin
                    n_state = pwic_pkg::SEQ_RUN;
                    n_pc    = '0;
                end
            end
            pwic_pkg::SEQ_RUN: begin
                o_ctl.exec = !w_hold;
                if (!w_hold) begin
                    if (w_jump) begin
                        n_pc = w_uw.target;
                    end else if (w_uw.last) begin
                        n_state = pwic_pkg::SEQ_IDLE;
                        n_pc    = '0;
                    end else begin
                        n_pc = r_pc + 1'b1;
                    end
                end
            end
            default: begin
                n_state = pwic_pkg::SEQ_IDLE;
                n_pc    = '0;
            end
        endcase
    end

    a_pc_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pwic_pkg::SEQ_RUN) |-> (r_pc < pwic_pkg::PC_W'(pwic_pkg::UCODE_LEN)))
        else $error("program counter outside the microcode");

    a_fire_starts_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_fire |=> (r_state == pwic_pkg::SEQ_RUN) && (r_pc == '0))
        else $error("accepted item did not start the program at step zero");

endmodule

// ----- rtl/pwic_dp.sv -----
// ----------------------------------------------------------------------------
// pwic_dp - PID datapath
// Input and state registers, one shared 32x32 multiplier, the clamp and sum
// logic, the serial divider and the output register.
// ----------------------------------------------------------------------------
module pwic_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_fire,
    input  logic signed [15:0]  i_setpoint,
    input  logic signed [15:0]  i_measured,
    input  logic [31:0]         i_time_stamp,
    input  pwic_pkg::t_cfg      i_cfg,
    input  pwic_pkg::t_ctl      i_ctl,
    input  logic                i_out_stall,
    output pwic_pkg::t_sts      o_sts,
    output logic                o_out_valid,
    output logic signed [15:0]  o_control_out,
    output logic                o_time_not_advanced
);

    // Captured item
    logic signed [15:0] r_sp;
    logic signed [15:0] r_meas;
    logic [31:0]        r_ts;

    // Working registers
    logic signed [15:0] r_err;
    logic [31:0]        r_dt;
    logic signed [16:0] r_derr;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_acc;
    logic signed [63:0] r_sum;

    // Controller state
    logic signed [15:0] r_last_err;
    logic signed [31:0] r_integ;
    logic [31:0]        r_last_time;

    // Output register
    logic               r_out_valid;
    logic signed [15:0] r_out;
    logic               r_tna;

    logic signed [16:0] w_diff;
    logic signed [15:0] w_err_sat;
    logic signed [16:0] w_derr;
    logic signed [31:0] w_ma;
    logic signed [31:0] w_mb;
    logic signed [63:0] w_mprod;
    logic signed [48:0] w_isum;
    logic signed [48:0] w_ilim;
    logic signed [48:0] w_iclamp;
    logic signed [63:0] w_kd_abs;
    logic [pwic_pkg::DIV_NUM_W-1:0]     w_num;
    logic signed [pwic_pkg::QUO_W-1:0]  w_quo;
    logic               w_div_busy;
    logic signed [37:0] w_sh;
    logic signed [37:0] w_olim;
    logic signed [37:0] w_oclamp;
    logic               w_go;

    assign w_go = i_ctl.exec;

    // Error, saturated to 16 bits, and its change since the last sample
    always_comb begin
        w_diff = {r_sp[15], r_sp} - {r_meas[15], r_meas};
        if (w_diff[16] != w_diff[15]) begin
            w_err_sat = w_diff[16] ? 16'sh8000 : 16'sh7fff;
        end else begin
            w_err_sat = w_diff[15:0];
        end
        w_derr = {w_err_sat[15], w_err_sat} - {r_last_err[15], r_last_err};
    end

    // Shared multiplier operand select
    always_comb begin
        case (i_ctl.mul)
            pwic_pkg::MUL_ERR_DT: begin
                w_ma = 32'(r_err);
                w_mb = $signed(r_dt);
            end
            pwic_pkg::MUL_KD_DERR: begin
                w_ma = 32'(i_cfg.deriv_gain);
                w_mb = 32'(r_derr);
            end
            pwic_pkg::MUL_KP_ERR: begin
                w_ma = 32'(i_cfg.prop_gain);
                w_mb = 32'(r_err);
            end
            pwic_pkg::MUL_KI_ACC: begin
                w_ma = 32'(i_cfg.integ_gain);
                w_mb = r_acc;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        w_mprod = w_ma * w_mb;
    end

    // Integral update and clamp
    always_comb begin
        w_isum = 49'(r_integ) + r_prod[48:0];
        w_ilim = $signed({24'd0, i_cfg.integ_limit, 10'd0});
        if (w_isum > w_ilim) begin
            w_iclamp = w_ilim;
        end else if (w_isum < -w_ilim) begin
            w_iclamp = -w_ilim;
        end else begin
            w_iclamp = w_isum;
        end
    end

    // Derivative numerator magnitude, scaled by 1024
    always_comb begin
        w_kd_abs = r_prod[63] ? -r_prod : r_prod;
        w_num    = {w_kd_abs[39:0], 10'd0};
    end

    // Floor shift of the sum to Q8.8, then output saturation
    always_comb begin
        w_sh   = r_sum[63:26];
        w_olim = $signed({23'd0, i_cfg.out_limit});
        if (w_sh > w_olim) begin
            w_oclamp = w_olim;
        end else if (w_sh < -w_olim) begin
            w_oclamp = -w_olim;
        end else begin
            w_oclamp = w_sh;
        end
    end

    pwic_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_go && i_ctl.div_start),
        .i_num   (w_num),
        .i_neg   (r_prod[63]),
        .i_den   (r_dt),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo)
    );

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_sp   <= i_setpoint;
            r_meas <= i_measured;
            r_ts   <= i_time_stamp;
        end
        if (w_go && (i_ctl.mul != pwic_pkg::MUL_NONE)) begin
            r_prod <= w_mprod;
        end
        if (w_go) begin
            case (i_ctl.alu)
                pwic_pkg::ALU_PREP: begin
                    r_err  <= w_err_sat;
                    r_derr <= w_derr;
                    r_dt   <= r_ts - r_last_time;
                end
                pwic_pkg::ALU_INTEG: begin
                    r_acc <= w_iclamp[31:0];
                end
                pwic_pkg::ALU_LOAD_P: begin
                    r_sum <= {r_prod[53:0], 10'd0};
                end
                pwic_pkg::ALU_ADD_I: begin
                    r_sum <= r_sum + r_prod;
                end
                pwic_pkg::ALU_ADD_D: begin
                    r_sum <= r_sum + $signed({{3{w_quo[pwic_pkg::QUO_W-1]}}, w_quo, 10'd0});
                end
                pwic_pkg::ALU_FINISH: begin
                    r_out <= w_oclamp[15:0];
                    r_tna <= 1'b0;
                end
                pwic_pkg::ALU_ZERO: begin
                    r_out <= '0;
                    r_tna <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Controller state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err  <= '0;
            r_integ     <= '0;
            r_last_time <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_go && (i_ctl.alu == pwic_pkg::ALU_FINISH)) begin
                r_last_err  <= r_err;
                r_integ     <= r_acc;
                r_last_time <= r_ts;
            end
            if (w_go && ((i_ctl.alu == pwic_pkg::ALU_FINISH) ||
                         (i_ctl.alu == pwic_pkg::ALU_ZERO))) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.dt_notpos = (r_dt == '0) || r_dt[31];
    assign o_sts.div_busy  = w_div_busy;
    assign o_sts.out_busy  = r_out_valid && i_out_stall;

    assign o_out_valid         = r_out_valid;
    assign o_control_out       = r_out;
    assign o_time_not_advanced = r_tna;

    a_integ_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && (i_ctl.alu == pwic_pkg::ALU_INTEG)) |=>
        (49'(r_acc) <= $signed({24'd0, i_cfg.integ_limit, 10'd0})) &&
        (49'(r_acc) >= -$signed({24'd0, i_cfg.integ_limit, 10'd0})))
        else $error("integral outside its clamp");

    a_finish_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && (i_ctl.alu == pwic_pkg::ALU_FINISH)) |=>
        r_out_valid && !r_tna &&
        (17'(r_out) <= $signed({2'd0, i_cfg.out_limit})) &&
        (17'(r_out) >= -$signed({2'd0, i_cfg.out_limit})))
        else $error("result outside the output limit");

endmodule

// ----- rtl/pid_with_integral_clamp_unit.sv -----
// ----------------------------------------------------------------------------
// pid_with_integral_clamp_unit - discrete PID controller, clamped integral
// A result is registered when the microcode program ends. The radix-4 serial
// divider for the derivative term dominates the run; when time did not advance
// the program skips it. One item is in flight at a time.
// Reset (synchronous, active low) restores gains/limits, zeroes the controller state.
// ----------------------------------------------------------------------------
//
// Structure
//   pwic_seq  steps a nine-word microcode program held in pwic_pkg. Each word
//             selects a multiplier operand pair, a datapath register operation,
//             an optional divider start and a condition (jump on a
//             non-positive time step, hold while the divider runs, hold while
//             the output register is still stalled).
//   pwic_dp   holds the captured item, the controller state, one shared
//             32x32 multiplier with a registered product, the clamp and sum
//             logic and the output register.
//   pwic_div  serial divider, two quotient bits per cycle, for the derivative
//             term divided by the time step (truncates toward zero).
//
// Program
//   0  form error (saturated), change of error and time step
//   1  multiply error by time step; jump to step 8 if the step is not positive
//   2  clamp the new integral; multiply derivative gain by change of error
//   3  start the divider; multiply proportional gain by error
//   4  load the proportional term into the sum; multiply integral gain by the
//      clamped integral; 5  add the integral term
//   6  hold until the divider is done, then add the derivative term
//   7  shift and saturate the sum into the output register, commit the state
//   8  (time not advanced) load zero with the flag set, leave state alone
//
// The output register parts the two channels: a new item is taken as soon as
// the program ends, even while the last result waits on a stalled output.
// The configuration port is always ready; writes to unknown indexes drop.
// ----------------------------------------------------------------------------
module pid_with_integral_clamp_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_setpoint,
    input  logic signed [15:0] i_measured,
    input  logic [31:0]        i_time_stamp,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_control_out,
    output logic               o_time_not_advanced,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    pwic_pkg::t_cfg r_cfg;
    pwic_pkg::t_cfg n_cfg;
    pwic_pkg::t_ctl w_ctl;
    pwic_pkg::t_sts w_sts;
    logic           w_idle;
    logic           w_in_fire;
    logic           w_cfg_fire;

    // Take a new item only while the sequencer is idle
    assign o_in_stall  = !w_idle;
    assign w_in_fire   = i_in_valid && w_idle;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_fire  = i_cfg_valid && o_cfg_ready;

    // Configuration register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (w_cfg_fire) begin
            case (pwic_pkg::t_cfg_idx'(i_cfg_index))
                pwic_pkg::CFG_PROP_GAIN:   n_cfg.prop_gain   = $signed(i_cfg_data);
                pwic_pkg::CFG_INTEG_GAIN:  n_cfg.integ_gain  = $signed(i_cfg_data);
                pwic_pkg::CFG_DERIV_GAIN:  n_cfg.deriv_gain  = $signed(i_cfg_data);
                pwic_pkg::CFG_INTEG_LIMIT: n_cfg.integ_limit = i_cfg_data[14:0];
                pwic_pkg::CFG_OUT_LIMIT:   n_cfg.out_limit   = i_cfg_data[14:0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain   <= pwic_pkg::CFG_RST_PROP_GAIN;
            r_cfg.integ_gain  <= pwic_pkg::CFG_RST_INTEG_GAIN;
            r_cfg.deriv_gain  <= pwic_pkg::CFG_RST_DERIV_GAIN;
            r_cfg.integ_limit <= pwic_pkg::CFG_RST_INTEG_LIMIT;
            r_cfg.out_limit   <= pwic_pkg::CFG_RST_OUT_LIMIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    pwic_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_fire (w_in_fire),
        .i_sts     (w_sts),
        .o_ctl     (w_ctl),
        .o_idle    (w_idle)
    );

    pwic_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_fire           (w_in_fire),
        .i_setpoint          (i_setpoint),
        .i_measured          (i_measured),
        .i_time_stamp        (i_time_stamp),
        .i_cfg               (r_cfg),
        .i_ctl               (w_ctl),
        .i_out_stall         (i_out_stall),
        .o_sts               (w_sts),
        .o_out_valid         (o_out_valid),
        .o_control_out       (o_control_out),
        .o_time_not_advanced (o_time_not_advanced)
    );

endmodule
